// ===== sv/pol_pkg.sv =====
`default_nettype none

package pol_pkg;

    localparam int DATA_W      = 32;
    localparam int POS_W       = 7;
    localparam int COUNT_W     = 5;
    localparam int MAX_RESULTS = 16;

    typedef enum logic [2:0] {
        ACT_APPEND    = 3'd0,
        ACT_PREPEND   = 3'd1,
        ACT_INSERT    = 3'd2,
        ACT_DEL_END   = 3'd3,
        ACT_DEL_FRONT = 3'd4,
        ACT_DEL_POS   = 3'd5,
        ACT_DUMP      = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_INSERT,
        CMD_DELETE,
        CMD_ROTATE
    } cmd_kind_t;

    // pos: insert/delete slot, or the last occupied slot for a rotate
    typedef struct packed {
        cmd_kind_t        kind;
        logic [POS_W-1:0] pos;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== sv/pol_cell.sv =====
`default_nettype none

module pol_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                      aclk,
    input  wire pol_pkg::cell_cmd_t        cmd,
    input  wire logic [pol_pkg::DATA_W-1:0] load_value,
    input  wire logic [pol_pkg::DATA_W-1:0] left_value,
    input  wire logic [pol_pkg::DATA_W-1:0] right_value,
    input  wire logic [pol_pkg::DATA_W-1:0] head_value,
    output logic      [pol_pkg::DATA_W-1:0] value
);
    import pol_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        case (cmd.kind)
            CMD_INSERT: begin
                if (MY_POS == cmd.pos) begin
                    value_next = load_value;
                end else if (MY_POS > cmd.pos) begin
                    value_next = left_value;
                end
            end
            CMD_DELETE: begin
                if (MY_POS >= cmd.pos) begin
                    value_next = right_value;
                end
            end
            CMD_ROTATE: begin
                // front entry wraps to the last occupied slot
                if (MY_POS == cmd.pos) begin
                    value_next = head_value;
                end else if (MY_POS < cmd.pos) begin
                    value_next = right_value;
                end
            end
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== sv/positional_ordered_list.sv =====
// Bounded ordered list of up to LIST_DEPTH signed 32-bit values, numbered
// from 1 at the front. Each request on the s_ channel is one operation:
// append, prepend, insert at position, delete end, delete front, delete at
// position, or dump. Every operation other than dump returns one result on
// the m_ channel with tlast set; a dump returns one result per entry, front
// to back (at most 16), tlast on the final one, or a single empty result.
// Sequence: a request is taken in the idle state and executed in the execute state
// once the output register is free, after which the next request is accepted. A dump
// steps once per held entry: the row of cells rotates by one place per cycle while the
// output register is free (or the result limit is passed), as the front cell is streamed
// out, and after occupancy steps the row is back in its original order.
// The result sits in an output register; while the receiver stalls it
// holds, the execute or dump step waits, and s_tready stays low until the
// current request is finished.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; cell contents are not cleared and are never read before written.
`default_nettype none

module positional_ordered_list #(
    parameter int LIST_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // action[2:0], value[34:3], position[39:35]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // status[1:0], entry_value[33:2], entry_count[38:34]
    output logic             m_tlast
);
    import pol_pkg::*;

    localparam int OCC_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          act_reg, act_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [4:0]          pos_reg, pos_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;
    logic [OCC_W-1:0]    rot_reg, rot_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [DATA_W-1:0]   m_value_reg, m_value_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;
    logic                m_last_reg, m_last_next;

    cell_cmd_t           cmd;
    logic [DATA_W-1:0]   cell_q [LIST_DEPTH];

    logic                out_free;
    logic [POS_W-1:0]    occ7, idx7, rot7, lim7;
    logic                full, empty, emitting;

    assign out_free = !m_valid_reg || m_tready;
    assign occ7     = POS_W'(occ_reg);
    assign rot7     = POS_W'(rot_reg);
    assign idx7     = (pos_reg == 5'd0) ? '0 : POS_W'(pos_reg - 5'd1);
    assign full     = (occ7 == POS_W'(LIST_DEPTH));
    assign empty    = (occ_reg == '0);
    assign lim7     = (occ7 > POS_W'(MAX_RESULTS)) ? POS_W'(MAX_RESULTS) : occ7;
    assign emitting = (rot7 < POS_W'(MAX_RESULTS));

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        occ_next      = occ_reg;
        rot_next      = rot_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        cmd.kind      = CMD_NONE;
        cmd.pos       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next   = s_tdata[2:0];
                    val_next   = s_tdata[34:3];
                    pos_next   = s_tdata[39:35];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next    = S_IDLE;
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_value_next  = '0;
                    m_last_next   = 1'b1;
                    case (act_reg)
                        ACT_APPEND, ACT_PREPEND, ACT_INSERT: begin
                            if (full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                cmd.kind = CMD_INSERT;
                                if (act_reg == ACT_APPEND) begin
                                    cmd.pos = occ7;
                                end else if (act_reg == ACT_PREPEND) begin
                                    cmd.pos = '0;
                                end else begin
                                    cmd.pos = (idx7 < occ7) ? idx7 : occ7;
                                end
                                occ_next = occ_reg + OCC_W'(1);
                            end
                        end
                        ACT_DEL_END, ACT_DEL_FRONT, ACT_DEL_POS: begin
                            if (empty) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                cmd.kind = CMD_DELETE;
                                if (act_reg == ACT_DEL_END) begin
                                    cmd.pos = occ7 - POS_W'(1);
                                end else if (act_reg == ACT_DEL_FRONT) begin
                                    cmd.pos = '0;
                                end else begin
                                    cmd.pos = (idx7 < occ7) ? idx7 : occ7 - POS_W'(1);
                                end
                                occ_next = occ_reg - OCC_W'(1);
                            end
                        end
                        ACT_DUMP: begin
                            if (empty) begin
                                m_status_next = ST_EMPTY;
                            end else begin
                                // hold the output slot; the dump loop fills it
                                m_valid_next = m_valid_reg && !m_tready;
                                rot_next     = '0;
                                state_next   = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                    m_count_next = COUNT_W'(occ_next);
                end
            end
            S_DUMP: begin
                // past the result limit keep rotating without output
                if (!emitting || out_free) begin
                    cmd.kind = CMD_ROTATE;
                    cmd.pos  = occ7 - POS_W'(1);
                    rot_next = rot_reg + OCC_W'(1);
                    if (emitting) begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_OK;
                        m_value_next  = cell_q[0];
                        m_count_next  = COUNT_W'(occ_reg);
                        m_last_next   = (rot7 == lim7 - POS_W'(1));
                    end
                    if (rot_reg == occ_reg - OCC_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            rot_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            rot_reg     <= rot_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg      <= act_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_v;
        logic [DATA_W-1:0] right_v;

        if (i == 0) begin : g_first
            assign left_v = cell_q[i];
        end else begin : g_mid_l
            assign left_v = cell_q[i-1];
        end
        if (i == LIST_DEPTH - 1) begin : g_last
            assign right_v = cell_q[i];
        end else begin : g_mid_r
            assign right_v = cell_q[i+1];
        end

        pol_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .load_value (val_reg),
            .left_value (left_v),
            .right_value(right_v),
            .head_value (cell_q[0]),
            .value      (cell_q[i])
        );
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_value_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ7 <= POS_W'(LIST_DEPTH))
        else $error("occupancy exceeds list depth");

    a_dump_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DUMP |-> !empty)
        else $error("dump running on an empty list");

    a_occ_step: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == $past(occ_reg) || occ_reg == $past(occ_reg) + OCC_W'(1)
        || occ_reg == $past(occ_reg) - OCC_W'(1))
        else $error("occupancy moved by more than one");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_EXEC)
        else $error("accepted request not executed");

endmodule

`default_nettype wire

// ===== tb/sv/tb_positional_ordered_list.sv =====
`default_nettype none

module tb_positional_ordered_list;
    import pol_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam int HOLD_CYCLES = 80;
    // action code with no operation behind it
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    typedef struct packed {
        status_t     status;
        logic [31:0] entry_value;
        logic [4:0]  entry_count;
        logic        last;
    } list_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // action[2:0], value[34:3], position[39:35]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // status[1:0], entry_value[33:2], entry_count[38:34]
    logic        m_tlast;

    logic [31:0]  list_contents[$];
    list_result_t expected_results[$];
    int           mismatch_count = 0;

    bit sender_gaps = 0;
    int burst_left  = 0;
    int rx_mode     = 0;
    bit hold_req    = 0;
    bit hold_active = 0;

    positional_ordered_list #(
        .LIST_DEPTH(LIST_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // list predictor ------------------------------------------------------

    task automatic list_insert(input int unsigned idx, input logic [31:0] val,
                               output status_t st);
        if (list_contents.size() >= LIST_DEPTH) begin
            st = ST_FULL;
        end else begin
            if (idx > list_contents.size()) idx = list_contents.size();
            list_contents.insert(idx, val);
            st = ST_OK;
        end
    endtask

    task automatic list_remove(input int unsigned idx, output status_t st);
        if (list_contents.size() == 0) begin
            st = ST_EMPTY;
        end else begin
            if (idx >= list_contents.size()) idx = list_contents.size() - 1;
            list_contents.delete(idx);
            st = ST_OK;
        end
    endtask

    task automatic predict_operation(input logic [2:0] act, input logic [31:0] val,
                                     input logic [4:0] pos);
        int unsigned  idx;
        int unsigned  n;
        status_t      st;
        list_result_t r;
        idx = (pos == 0) ? 0 : pos - 1;
        st  = ST_OK;
        case (act)
            ACT_APPEND:    list_insert(list_contents.size(), val, st);
            ACT_PREPEND:   list_insert(0, val, st);
            ACT_INSERT:    list_insert(idx, val, st);
            ACT_DEL_END:   list_remove(list_contents.size(), st);
            ACT_DEL_FRONT: list_remove(0, st);
            ACT_DEL_POS:   list_remove(idx, st);
            ACT_DUMP: begin
                if (list_contents.size() == 0) begin
                    st = ST_EMPTY;
                end else begin
                    n = list_contents.size();
                    if (n > MAX_RESULTS) n = MAX_RESULTS;
                    for (int i = 0; i < n; i++) begin
                        r.status      = ST_OK;
                        r.entry_value = list_contents[i];
                        r.entry_count = 5'(list_contents.size());
                        r.last        = (i == n - 1);
                        expected_results.push_back(r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        r.status      = st;
        r.entry_value = '0;
        r.entry_count = 5'(list_contents.size());
        r.last        = 1'b1;
        expected_results.push_back(r);
    endtask

    // predict on every accepted request, check every accepted result
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_operation(s_tdata[2:0], s_tdata[34:3], s_tdata[39:35]);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[31:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
                    if (m_tdata[33:2] !== want.entry_value)
                        report_mismatch("entry_value", m_tdata[33:2], want.entry_value);
                    if (m_tdata[38:34] !== want.entry_count)
                        report_mismatch("entry_count", 32'(m_tdata[38:34]),
                                        32'(want.entry_count));
                    if (m_tlast !== want.last)
                        report_mismatch("tlast", 32'(m_tlast), 32'(want.last));
                end
            end
        end
    end

    // receiver: selectable stall pattern, plus a long hold-off on demand
    initial begin
        int tick;
        tick     = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req) begin
                m_tready    <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ((tick % 7) >= 3);
                endcase
            end
        end
    end

    // sender -----------------------------------------------------------------

    task automatic send_request(input logic [2:0] act, input logic [31:0] val,
                                input logic [4:0] pos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = sender_gaps ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, val, act};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        @(posedge aclk);
    endtask

    // tests --------------------------------------------------------------------

    task automatic test_empty_list();
        sender_gaps = 0;
        rx_mode     = 0;
        send_request(ACT_DUMP, '0, '0);
        send_request(ACT_DEL_END, '0, '0);
        send_request(ACT_DEL_FRONT, '0, '0);
        send_request(ACT_DEL_POS, '0, 5'd0);
        send_request(ACT_UNUSED, 32'hFFFF_FFFF, 5'd31);
        wait_drained();
    endtask

    task automatic test_positions();
        rx_mode = 1;
        send_request(ACT_APPEND, 32'h7FFF_FFFF, '0);
        send_request(ACT_PREPEND, 32'h8000_0000, '0);
        send_request(ACT_INSERT, 32'h0000_0000, 5'd0);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 5'd1);
        // past the end: append
        send_request(ACT_INSERT, 32'h5555_5555, 5'd31);
        send_request(ACT_INSERT, 32'hAAAA_AAAA, 5'd3);
        send_request(ACT_DUMP, '0, '0);
        send_request(ACT_DEL_POS, '0, 5'd0);
        send_request(ACT_DEL_POS, '0, 5'd31);
        send_request(ACT_DEL_POS, '0, 5'd2);
        send_request(ACT_DEL_FRONT, '0, '0);
        send_request(ACT_DEL_END, '0, '0);
        send_request(ACT_DUMP, '0, '0);
        send_request(ACT_UNUSED, '0, '0);
        wait_drained();
    endtask

    task automatic test_full_list();
        rx_mode = 2;
        while (list_contents.size() < LIST_DEPTH)
            send_request(ACT_APPEND, $urandom(), 5'($urandom_range(0, 31)));
        send_request(ACT_APPEND, 32'h1234_5678, '0);
        send_request(ACT_PREPEND, 32'h1234_5678, '0);
        send_request(ACT_INSERT, 32'h1234_5678, 5'd4);
        send_request(ACT_DUMP, '0, '0);
        send_request(ACT_DEL_POS, '0, 5'd31);
        wait_drained();
    endtask

    task automatic test_output_stall();
        rx_mode     = 0;
        sender_gaps = 0;
        hold_req    = 1'b1;
        wait (hold_active);
        // keep offering while the receiver is held off
        send_request(ACT_DUMP, '0, '0);
        send_request(ACT_APPEND, $urandom(), '0);
        send_request(ACT_PREPEND, $urandom(), '0);
        send_request(ACT_DUMP, '0, '0);
        send_request(ACT_DEL_POS, '0, 5'd3);
        send_request(ACT_INSERT, $urandom(), 5'd2);
        send_request(ACT_DEL_FRONT, '0, '0);
        send_request(ACT_DUMP, '0, '0);
        wait_drained();
    endtask

    task automatic test_random_ops(input int total);
        int          sent;
        int          phase_kind;
        int          phase_len;
        int          roll;
        logic [2:0]  act;
        logic [4:0]  pos;
        sent = 0;
        while (sent < total) begin
            phase_kind  = $urandom_range(0, 2);
            phase_len   = $urandom_range(10, 40);
            sender_gaps = ($urandom_range(0, 2) != 0);
            rx_mode     = $urandom_range(0, 2);
            for (int k = 0; k < phase_len && sent < total; k++) begin
                roll = $urandom_range(0, 99);
                case (phase_kind)
                    0: begin    // fill
                        if (roll < 70)      act = 3'($urandom_range(0, 2));
                        else if (roll < 85) act = 3'($urandom_range(3, 5));
                        else if (roll < 96) act = ACT_DUMP;
                        else                act = ACT_UNUSED;
                    end
                    1: begin    // drain
                        if (roll < 70)      act = 3'($urandom_range(3, 5));
                        else if (roll < 85) act = 3'($urandom_range(0, 2));
                        else if (roll < 96) act = ACT_DUMP;
                        else                act = ACT_UNUSED;
                    end
                    default: begin
                        if (roll < 95) act = 3'($urandom_range(0, 6));
                        else           act = ACT_UNUSED;
                    end
                endcase
                if ($urandom_range(0, 4) != 0)
                    pos = 5'($urandom_range(0, list_contents.size() + 1));
                else
                    pos = 5'($urandom_range(0, 31));
                send_request(act, $urandom(), pos);
                sent++;
            end
        end
        wait_drained();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_list();
        test_positions();
        test_full_list();
        test_output_stall();
        test_random_ops(400);

        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/pol_pkg.sv
sv/pol_cell.sv
sv/positional_ordered_list.sv
tb/sv/tb_positional_ordered_list.sv
